FILE: rtl/core/lcqt_pkg.sv
// Shared types and character codes for the line comment quote tokenizer.
package lcqt_pkg;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_LINE_START = 3'd0,
    MODE_COMMENT    = 3'd1,
    MODE_BETWEEN    = 3'd2,
    MODE_UNQUOTED   = 3'd3,
    MODE_QUOTED     = 3'd4,
    MODE_ESCAPE     = 3'd5
  } mode_t;

  // Character codes
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // One result item
  typedef struct packed {
    logic       first_on_line;
    logic       has_byte;
    logic       token_last;
    logic [7:0] token_byte;
  } result_t;

endpackage

FILE: rtl/core/line_comment_quote_tokenizer.sv
// Top level: byte-per-item tokenizer for comment-aware configuration text.
// Results are registered; one waits in the skid register while m_* is held.
// Throughput: one item per cycle while s_tready is high; the scanner state update is the only loop.
// A two-entry output (result register plus skid register) keeps s_tready up
// while one result waits; s_tready drops only while the skid entry is full.
// Reset (rst, synchronous): line start mode, first flag set, both entries empty.
module line_comment_quote_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] token_byte
  output logic [1:0] m_tuser,   // [0] has_byte, [1] first_on_line
  output logic       m_tlast    // token_last
);
  import lcqt_pkg::*;

  mode_t   mode;
  mode_t   mode_next;
  mode_t   mode_mid;
  logic    first_pending;
  logic    first_pending_next;
  logic    emit;
  logic    has;
  logic    last;
  logic    in_fire;
  logic    out_fire;
  logic    is_blank;
  logic    is_eol;
  logic    is_cmt;
  result_t res;
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = !skid_valid;

  // Classify the incoming byte
  assign is_blank = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
  assign is_eol   = (s_tdata == CH_LF) || (s_tdata == CH_CR);
  assign is_cmt   = (s_tdata == CH_SLASH) || (s_tdata == CH_SEMICOLON) ||
                    (s_tdata == CH_HASH);

  // Next state
  always_comb begin
    mode_mid           = mode;
    first_pending_next = first_pending;
    case (mode)
      MODE_COMMENT: begin
        if (is_eol) mode_mid = MODE_LINE_START;
      end
      MODE_UNQUOTED: begin
        if (is_eol) begin
          mode_mid           = MODE_LINE_START;
          first_pending_next = 1'b1;
        end else if (is_blank) begin
          mode_mid           = MODE_BETWEEN;
          first_pending_next = 1'b0;
        end
      end
      MODE_QUOTED: begin
        if (s_tdata == CH_QUOTE) begin
          mode_mid           = MODE_BETWEEN;
          first_pending_next = 1'b0;
        end else if (s_tdata == CH_BACKSLASH) begin
          mode_mid = MODE_ESCAPE;
        end
      end
      MODE_ESCAPE: begin
        mode_mid = MODE_QUOTED;
      end
      default: begin
        // Line start, between tokens, and unused codes
        if (is_blank) begin
          mode_mid = (mode == MODE_BETWEEN) ? MODE_BETWEEN : MODE_LINE_START;
        end else if (is_eol) begin
          mode_mid           = MODE_LINE_START;
          first_pending_next = 1'b1;
        end else if (mode != MODE_BETWEEN && is_cmt) begin
          mode_mid = MODE_COMMENT;
        end else if (s_tdata == CH_QUOTE) begin
          mode_mid = MODE_QUOTED;
        end else begin
          mode_mid = MODE_UNQUOTED;
        end
      end
    endcase
    mode_next = mode_mid;
    // End of text returns to the reset state
    if (s_tlast) begin
      mode_next          = MODE_LINE_START;
      first_pending_next = 1'b1;
    end
  end

  // Outputs of the scanner
  always_comb begin
    emit = 1'b0;
    has  = 1'b0;
    last = 1'b0;
    case (mode)
      MODE_COMMENT: ;
      MODE_UNQUOTED: begin
        emit = 1'b1;
        if (is_blank || is_eol) last = 1'b1;
        else                    has  = 1'b1;
      end
      MODE_QUOTED: begin
        if (s_tdata == CH_QUOTE) begin
          emit = 1'b1;
          last = 1'b1;
        end else if (s_tdata != CH_BACKSLASH) begin
          emit = 1'b1;
          has  = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        emit = 1'b1;
        has  = 1'b1;
      end
      default: begin
        if (!is_blank && !is_eol && !(mode != MODE_BETWEEN && is_cmt) &&
            s_tdata != CH_QUOTE) begin
          emit = 1'b1;
          has  = 1'b1;
        end
      end
    endcase
    // Close any open token at end of text
    if (s_tlast && (mode_mid == MODE_UNQUOTED || mode_mid == MODE_QUOTED ||
                    mode_mid == MODE_ESCAPE)) begin
      emit = 1'b1;
      last = 1'b1;
    end
    res.token_byte    = has ? s_tdata : 8'd0;
    res.has_byte      = has;
    res.token_last    = last;
    res.first_on_line = first_pending;
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_LINE_START;
      first_pending <= 1'b1;
    end else if (in_fire) begin
      mode          <= mode_next;
      first_pending <= first_pending_next;
    end
  end

  // Result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= in_fire && emit;
      end
    end else if (in_fire && emit) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: load the result register, park in skid when it is held
  always_ff @(posedge clk) begin
    if (out_fire || !m_tvalid) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (in_fire && emit) begin
      skid_reg <= res;
    end
  end

  assign m_tdata = out_reg.token_byte;
  assign m_tuser = {out_reg.first_on_line, out_reg.has_byte};
  assign m_tlast = out_reg.token_last;

endmodule

FILE: rtl/core/lcqt_checker.sv
// Port-level checker for the tokenizer, bound to the top level.
module lcqt_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Every result carries a byte or an end marker, and a byteless one reads zero
  a_content: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || m_tlast) && (m_tuser[0] || m_tdata == 8'd0))
    else $error("empty or malformed result");

  // No result out of an empty output without an accepted item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
    else $error("result without an accepted item");

endmodule

bind line_comment_quote_tokenizer lcqt_checker u_lcqt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: sim/line_comment_quote_tokenizer_tb.sv
// Testbench for the line comment quote tokenizer: directed table, random text, scoreboard.
`timescale 1ns / 1ps

module line_comment_quote_tokenizer_tb;
  import lcqt_pkg::*;

  localparam int N_RANDOM     = 2000;
  localparam int HOLD_AT_ITEM = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  // One row of directed stimulus; typed rows carry their own expected result
  typedef struct {
    logic [7:0] text_byte;
    logic       eot;
    bit         typed;
    bit         emits;
    result_t    res;
  } text_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] text_byte
  logic       s_tlast;   // end_of_text
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] token_byte
  logic [1:0] m_tuser;   // [0] has_byte, [1] first_on_line
  logic       m_tlast;   // token_last

  // Predictor state
  mode_t      scan_mode_q;
  logic       first_pending_q;

  text_row_t  dir_rows[$];
  text_row_t  sent_rows[$];
  result_t    token_q[$];
  int         err_cnt = 0;
  int         n_taken = 0;

  line_comment_quote_tokenizer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // Run limit, far above the slowest legal run
  initial begin
    #12_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic result_t tok(input logic first, input logic has, input logic last,
                                  input logic [7:0] b);
    result_t r;
    r.first_on_line = first;
    r.has_byte      = has;
    r.token_last    = last;
    r.token_byte    = b;
    return r;
  endfunction

  // Advance the scanner by one text byte; return 1 when a result is produced
  function automatic bit tokenize_byte(input logic [7:0] c, input logic eot,
                                       output result_t r);
    mode_t mode;
    logic  first;
    bit    emit, has, last, blank, eol;
    mode  = scan_mode_q;
    first = first_pending_q;
    emit  = 0;
    has   = 0;
    last  = 0;
    blank = (c == CH_SPACE) || (c == CH_TAB);
    eol   = (c == CH_LF) || (c == CH_CR);
    case (mode)
      MODE_COMMENT: begin
        if (eol) mode = MODE_LINE_START;
      end
      MODE_LINE_START, MODE_BETWEEN: begin
        if (blank) begin
        end else if (eol) begin
          mode            = MODE_LINE_START;
          first_pending_q = 1'b1;
        end else if (mode == MODE_LINE_START &&
                     (c == CH_SLASH || c == CH_SEMICOLON || c == CH_HASH)) begin
          mode = MODE_COMMENT;
        end else if (c == CH_QUOTE) begin
          mode = MODE_QUOTED;
        end else begin
          emit = 1;
          has  = 1;
          mode = MODE_UNQUOTED;
        end
      end
      MODE_UNQUOTED: begin
        emit = 1;
        if (blank || eol) begin
          last            = 1;
          mode            = eol ? MODE_LINE_START : MODE_BETWEEN;
          first_pending_q = eol;
        end else begin
          has = 1;
        end
      end
      MODE_QUOTED: begin
        if (c == CH_QUOTE) begin
          emit            = 1;
          last            = 1;
          mode            = MODE_BETWEEN;
          first_pending_q = 1'b0;
        end else if (c == CH_BACKSLASH) begin
          mode = MODE_ESCAPE;
        end else begin
          emit = 1;
          has  = 1;
        end
      end
      default: begin
        // escaped byte is taken literally
        emit = 1;
        has  = 1;
        mode = MODE_QUOTED;
      end
    endcase
    // close any open token at end of text and start over
    if (eot) begin
      if (mode == MODE_UNQUOTED || mode == MODE_QUOTED || mode == MODE_ESCAPE) begin
        emit = 1;
        last = 1;
      end
      mode            = MODE_LINE_START;
      first_pending_q = 1'b1;
    end
    scan_mode_q = mode;
    r = tok(first, has, last, has ? c : 8'h00);
    return emit;
  endfunction

  task automatic flag_error(input string what);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) $display("ERROR: %s", what);
  endtask

  // Predict on each accepted text item, check each accepted token item
  always @(posedge clk) begin : scoreboard
    text_row_t row;
    result_t   calc, want;
    bit        emit;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        row  = sent_rows.pop_front();
        emit = tokenize_byte(s_tdata, s_tlast, calc);
        if (row.typed) begin
          if (row.emits) token_q.push_back(row.res);
        end else if (emit) begin
          token_q.push_back(calc);
        end
        n_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          flag_error($sformatf("unexpected result byte=%h has=%b last=%b first=%b",
                               m_tdata, m_tuser[0], m_tlast, m_tuser[1]));
        end else begin
          want = token_q.pop_front();
          if (m_tdata !== want.token_byte || m_tuser[0] !== want.has_byte ||
              m_tlast !== want.token_last || m_tuser[1] !== want.first_on_line)
            flag_error($sformatf(
              "expected byte=%h has=%b last=%b first=%b, got byte=%h has=%b last=%b first=%b",
              want.token_byte, want.has_byte, want.token_last, want.first_on_line,
              m_tdata, m_tuser[0], m_tlast, m_tuser[1]));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Text with plenty of structure: tokens, blanks, line ends, quotes, escapes, comments
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'($urandom_range(0, 255));
    if (r < 47) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 58) return ($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE;
    if (r < 70) return ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF;
    if (r < 79) return CH_QUOTE;
    if (r < 85) return CH_BACKSLASH;
    case ($urandom_range(0, 2))
      0:       return CH_SLASH;
      1:       return CH_SEMICOLON;
      default: return CH_HASH;
    endcase
  endfunction

  task automatic add_row(input logic [7:0] b, input logic eot, input bit typed,
                         input bit emits, input result_t r);
    text_row_t row;
    row.text_byte = b;
    row.eot       = eot;
    row.typed     = typed;
    row.emits     = emits;
    row.res       = r;
    dir_rows.push_back(row);
  endtask

  // Offer one text item after a gap; return at the falling edge after it is taken
  task automatic send_text(input text_row_t row, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sent_rows.push_back(row);
    s_tvalid <= 1'b1;
    s_tdata  <= row.text_byte;
    s_tlast  <= row.eot;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Hold the input until every expected token item has arrived
  task automatic drain_tokens();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (token_q.size() != 0 || sent_rows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stalls, quiet runs, and one long hold-off
  initial begin : receiver
    bit hold_done;
    int quiet_left;
    int stall;
    hold_done  = 0;
    quiet_left = 0;
    m_tready   = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && n_taken >= HOLD_AT_ITEM) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1;
      end else begin
        if (quiet_left > 0) begin
          quiet_left--;
          stall = 0;
        end else begin
          if ($urandom_range(0, 63) == 0) quiet_left = $urandom_range(30, 100);
          stall = pick_gap();
        end
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // Sender: directed table, then random text
  initial begin : sender
    text_row_t row;
    result_t   none;
    int        quiet_left;
    int        gap;
    none       = '0;
    quiet_left = 0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = 8'h00;
    s_tlast    = 1'b0;
    scan_mode_q     = MODE_LINE_START;
    first_pending_q = 1'b1;

    // blanks and comment lines after reset give nothing
    add_row(CH_SPACE,     1'b0, 1, 0, none);
    add_row(CH_TAB,       1'b0, 1, 0, none);
    add_row(CH_HASH,      1'b0, 1, 0, none);
    add_row(8'h41,        1'b0, 1, 0, none);
    add_row(CH_LF,        1'b0, 1, 0, none);
    add_row(CH_SEMICOLON, 1'b0, 1, 0, none);
    add_row(CH_CR,        1'b0, 1, 0, none);
    add_row(CH_SLASH,     1'b0, 1, 0, none);
    add_row(8'hFF,        1'b0, 1, 0, none);
    add_row(CH_LF,        1'b0, 1, 0, none);
    // lowest byte opens a token; comment mark inside a token is plain data
    add_row(8'h00,        1'b0, 1, 1, tok(1'b1, 1'b1, 1'b0, 8'h00));
    add_row(CH_HASH,      1'b0, 0, 0, none);
    add_row(CH_SPACE,     1'b0, 0, 0, none);
    // highest byte as second token on the line
    add_row(8'hFF,        1'b0, 1, 1, tok(1'b0, 1'b1, 1'b0, 8'hFF));
    add_row(CH_TAB,       1'b0, 0, 0, none);
    // empty quoted token
    add_row(CH_QUOTE,     1'b0, 0, 0, none);
    add_row(CH_QUOTE,     1'b0, 0, 0, none);
    // escaped quote, line end inside quotes, escape closed by end of text
    add_row(CH_QUOTE,     1'b0, 0, 0, none);
    add_row(CH_BACKSLASH, 1'b0, 0, 0, none);
    add_row(CH_QUOTE,     1'b0, 0, 0, none);
    add_row(CH_LF,        1'b0, 0, 0, none);
    add_row(CH_BACKSLASH, 1'b0, 0, 0, none);
    add_row(CH_BACKSLASH, 1'b1, 0, 0, none);
    // one-byte text
    add_row(8'h7A,        1'b1, 1, 1, tok(1'b1, 1'b1, 1'b1, 8'h7A));
    // backslash as last byte drops the escape
    add_row(CH_QUOTE,     1'b0, 0, 0, none);
    add_row(CH_BACKSLASH, 1'b1, 0, 0, none);
    // token ended by a line end keeps the first flag
    add_row(8'h71,        1'b0, 0, 0, none);
    add_row(CH_CR,        1'b0, 0, 0, none);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_text(dir_rows[i], pick_gap());
    drain_tokens();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_tokens();
      if (quiet_left > 0) begin
        quiet_left--;
        gap = 0;
      end else begin
        if ($urandom_range(0, 99) == 0) quiet_left = $urandom_range(40, 120);
        gap = pick_gap();
      end
      row.text_byte = pick_text_byte();
      row.eot       = ($urandom_range(0, 79) == 0);
      row.typed     = 0;
      row.emits     = 0;
      row.res       = none;
      send_text(row, gap);
    end
    s_tvalid <= 1'b0;

    // let the last results out, then watch for strays
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (token_q.size() != 0) flag_error("expected results left over");
    if (err_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/lcqt_pkg.sv
rtl/core/line_comment_quote_tokenizer.sv
rtl/core/lcqt_checker.sv
sim/line_comment_quote_tokenizer_tb.sv
